// ===== rtl/mswlf_pkg.sv =====
// Shared constants, types and helper functions for the max-sum flagged window block.
// No dependencies; every other file except mswlf_ram refers to it by scoped names.
package mswlf_pkg;

  localparam int WINDOW_DEPTH = 1024;
  localparam int VALUE_BITS   = 16;

  // Fixed port field widths
  localparam int VALUE_W   = 16;
  localparam int LIMIT_W   = 11;
  localparam int OUT_SUM_W = 26;

  localparam int ADDR_W  = $clog2(WINDOW_DEPTH);
  localparam int CNT_W   = $clog2(WINDOW_DEPTH + 1);
  localparam int SUM_W   = VALUE_BITS + CNT_W;
  localparam int ENTRY_W = VALUE_BITS + 1;
  localparam int CMP_W   = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;
  localparam int WIDE_W  = (SUM_W > OUT_SUM_W) ? SUM_W : OUT_SUM_W;

  typedef logic [ADDR_W-1:0]     addr_t;
  typedef logic [CNT_W-1:0]      cnt_t;
  typedef logic [SUM_W-1:0]      sum_t;
  typedef logic [VALUE_BITS-1:0] val_t;
  typedef logic [VALUE_W-1:0]    in_val_t;
  typedef logic [LIMIT_W-1:0]    limit_t;
  typedef logic [OUT_SUM_W-1:0]  osum_t;
  typedef logic [ENTRY_W-1:0]    entry_t;

  // Controller -> datapath
  typedef struct packed {
    logic latch;       // capture the incoming item
    logic push;        // append an item at the tail
    logic push_src_in; // push from the input port, else from the latched item
    logic rd_en;       // issue a store read
    logic rd_next;     // read at the entry after head
    logic pop;         // drop the head entry using the read data
    logic ovf_set;     // raise the sticky overflow
    logic finish;      // update best and load the result register
  } cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic full;
    logic need_evict;
    logic pop_flag;
    logic pop_last;
    cnt_t cnt;
    cnt_t flag_cnt;
    logic ovf;
  } status_t;

  function automatic addr_t next_ptr(addr_t p);
    return (p == addr_t'(WINDOW_DEPTH - 1)) ? '0 : p + addr_t'(1);
  endfunction

  function automatic osum_t sat_out(sum_t s);
    logic [WIDE_W-1:0] w;
    w = WIDE_W'(s);
    if (w > WIDE_W'({OUT_SUM_W{1'b1}})) return '1;
    return OUT_SUM_W'(w);
  endfunction

endpackage

// ===== rtl/mswlf_if.sv =====
// Valid/ready channel interfaces for the item input and the result output.
// Depends on mswlf_pkg for field widths.
interface mswlf_in_if;
  logic                         valid;
  logic                         ready;
  logic                         flagged;
  logic [mswlf_pkg::VALUE_W-1:0] value;
  modport source (output valid, flagged, value, input ready);
  modport sink   (input valid, flagged, value, output ready);
endinterface

interface mswlf_out_if;
  logic                           valid;
  logic                           ready;
  logic [mswlf_pkg::OUT_SUM_W-1:0] best_sum;
  logic [mswlf_pkg::OUT_SUM_W-1:0] window_sum;
  logic                           overflow;
  modport source (output valid, best_sum, window_sum, overflow, input ready);
  modport sink   (input valid, best_sum, window_sum, overflow, output ready);
endinterface

// ===== rtl/mswlf_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mswlf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/mswlf_datapath.sv =====
// Window pointers, counters, sums, the window store and the result register.
// Depends on mswlf_pkg and mswlf_ram; driven by commands from mswlf_ctrl.
module mswlf_datapath (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  mswlf_pkg::limit_t          cfg_wdata,
  input  logic                       in_flagged,
  input  mswlf_pkg::in_val_t         in_value,
  input  mswlf_pkg::cmd_t            cmd,
  output mswlf_pkg::status_t         st,
  output mswlf_pkg::osum_t           out_best_sum,
  output mswlf_pkg::osum_t           out_window_sum,
  output logic                       out_overflow
);

  mswlf_pkg::addr_t  head_r, head_nxt, tail_r, tail_nxt, raddr;
  mswlf_pkg::cnt_t   cnt_r, cnt_nxt, fcnt_r, fcnt_nxt;
  mswlf_pkg::sum_t   sum_r, sum_nxt, best_r, best_nxt;
  mswlf_pkg::limit_t limit_r;
  logic              ovf_r;
  logic              item_flag_r;
  mswlf_pkg::val_t   item_val_r;
  mswlf_pkg::osum_t  out_best_r, out_win_r;
  logic              out_ovf_r;

  logic              push_flag;
  mswlf_pkg::val_t   push_val;
  mswlf_pkg::entry_t rdata;
  logic              rd_flag;
  mswlf_pkg::val_t   rd_val;

  assign push_flag = cmd.push_src_in ? in_flagged : item_flag_r;
  assign push_val  = cmd.push_src_in ? mswlf_pkg::val_t'(in_value) : item_val_r;
  assign raddr     = cmd.rd_next ? mswlf_pkg::next_ptr(head_r) : head_r;
  assign rd_flag   = rdata[mswlf_pkg::ENTRY_W-1];
  assign rd_val    = rdata[mswlf_pkg::VALUE_BITS-1:0];

  mswlf_ram #(
    .WIDTH(mswlf_pkg::ENTRY_W),
    .DEPTH(mswlf_pkg::WINDOW_DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (cmd.push),
    .waddr(tail_r),
    .wdata({push_flag, push_val}),
    .re   (cmd.rd_en),
    .raddr(raddr),
    .rdata(rdata)
  );

  always_comb begin
    head_nxt = head_r;
    tail_nxt = tail_r;
    cnt_nxt  = cnt_r;
    sum_nxt  = sum_r;
    fcnt_nxt = fcnt_r;
    if (cmd.push) begin
      tail_nxt = mswlf_pkg::next_ptr(tail_r);
      cnt_nxt  = cnt_r + mswlf_pkg::cnt_t'(1);
      sum_nxt  = sum_r + mswlf_pkg::sum_t'(push_val);
      fcnt_nxt = fcnt_r + mswlf_pkg::cnt_t'(push_flag);
    end else if (cmd.pop) begin
      head_nxt = mswlf_pkg::next_ptr(head_r);
      cnt_nxt  = cnt_r - mswlf_pkg::cnt_t'(1);
      sum_nxt  = sum_r - mswlf_pkg::sum_t'(rd_val);
      if (rd_flag && fcnt_r != '0) fcnt_nxt = fcnt_r - mswlf_pkg::cnt_t'(1);
    end
    best_nxt = (sum_r > best_r) ? sum_r : best_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      cnt_r   <= '0;
      sum_r   <= '0;
      fcnt_r  <= '0;
      best_r  <= '0;
      ovf_r   <= 1'b0;
      limit_r <= '0;
    end else begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      cnt_r  <= cnt_nxt;
      sum_r  <= sum_nxt;
      fcnt_r <= fcnt_nxt;
      if (cmd.finish) best_r <= best_nxt;
      if (cmd.ovf_set) ovf_r <= 1'b1;
      if (cfg_we) limit_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      item_flag_r <= in_flagged;
      item_val_r  <= mswlf_pkg::val_t'(in_value);
    end
    if (cmd.finish) begin
      out_best_r <= mswlf_pkg::sat_out(best_nxt);
      out_win_r  <= mswlf_pkg::sat_out(sum_r);
      out_ovf_r  <= ovf_r;
    end
  end

  assign st.full       = (cnt_r == mswlf_pkg::cnt_t'(mswlf_pkg::WINDOW_DEPTH));
  assign st.need_evict = (mswlf_pkg::CMP_W'(fcnt_r) > mswlf_pkg::CMP_W'(limit_r))
                         && (cnt_r != '0);
  assign st.pop_flag   = rd_flag;
  assign st.pop_last   = (cnt_r == mswlf_pkg::cnt_t'(1));
  assign st.cnt        = cnt_r;
  assign st.flag_cnt   = fcnt_r;
  assign st.ovf        = ovf_r;

  assign out_best_sum   = out_best_r;
  assign out_window_sum = out_win_r;
  assign out_overflow   = out_ovf_r;

endmodule

// ===== rtl/mswlf_ctrl.sv =====
// Sequencer for one item: optional overflow pop, push, eviction loop, result load.
// Depends on mswlf_pkg; drives mswlf_datapath through cmd_t.
module mswlf_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  mswlf_pkg::status_t  st,
  output mswlf_pkg::cmd_t     cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_OVF   = 3'd1;
  localparam logic [2:0] S_PUSH  = 3'd2;
  localparam logic [2:0] S_CHECK = 3'd3;
  localparam logic [2:0] S_POP   = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (st.full) begin
            // oldest entry sits where the new one goes: read it first
            cmd.latch = 1'b1;
            cmd.rd_en = 1'b1;
            state_nxt = S_OVF;
          end else begin
            cmd.push        = 1'b1;
            cmd.push_src_in = 1'b1;
            state_nxt       = S_CHECK;
          end
        end
      end
      S_OVF: begin
        cmd.pop     = 1'b1;
        cmd.ovf_set = 1'b1;
        state_nxt   = S_PUSH;
      end
      S_PUSH: begin
        cmd.push  = 1'b1;
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        if (st.need_evict) begin
          cmd.rd_en = 1'b1;
          state_nxt = S_POP;
        end else if (out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_POP: begin
        cmd.pop = 1'b1;
        if (st.pop_flag || st.pop_last) begin
          state_nxt = S_DONE;
        end else begin
          // prefetch the entry behind the one leaving now
          cmd.rd_en   = 1'b1;
          cmd.rd_next = 1'b1;
        end
      end
      S_DONE: begin
        if (out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    priority if (cmd.finish) out_valid_nxt = 1'b1;
    else if (out_ready)      out_valid_nxt = 1'b0;
    else                     out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ===== rtl/max_sum_window_limited_flags.sv =====
// Top level of the max-sum flagged window block: controller, datapath, channel ports.
// Depends on mswlf_pkg, mswlf_if, mswlf_ctrl and mswlf_datapath.
//
// Use:
//   in_item (valid/ready) carries one item: flagged bit and 16-bit value. Each item
//   yields exactly one result on out_result: best_sum, window_sum and sticky overflow.
//   cfg_we/cfg_wdata load flag_limit; write it only while no item is in flight.
// Timing:
//   An item is taken only while the sequencer is idle. With no eviction it passes
//   through accept (with the store write), then check and result load; the result
//   is valid the cycle after that. A full window adds the read and pop of the
//   oldest entry, then the delayed push. Each entry evicted by the flag limit adds
//   a pop step, plus a final step to finish. The single read port of the window
//   store paces the eviction loop at one entry per cycle.
// Stall:
//   The result sits in an output register; the next item is accepted while it waits.
//   If the new result is ready before the old one is taken, the sequencer holds.
// Reset:
//   rst_n (synchronous) empties the window, clears sums, overflow and flag_limit.
//   The store contents are not cleared; only written entries are ever read.
module max_sum_window_limited_flags (
  input  logic                clk,
  input  logic                rst_n,
  mswlf_in_if.sink            in_item,
  mswlf_out_if.source         out_result,
  input  logic                cfg_we,
  input  mswlf_pkg::limit_t   cfg_wdata
);

  mswlf_pkg::cmd_t    cmd;
  mswlf_pkg::status_t st;

  mswlf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_item.valid),
    .in_ready (in_item.ready),
    .out_valid(out_result.valid),
    .out_ready(out_result.ready),
    .st       (st),
    .cmd      (cmd)
  );

  mswlf_datapath u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .in_flagged    (in_item.flagged),
    .in_value      (in_item.value),
    .cmd           (cmd),
    .st            (st),
    .out_best_sum  (out_result.best_sum),
    .out_window_sum(out_result.window_sum),
    .out_overflow  (out_result.overflow)
  );

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    st.cnt <= mswlf_pkg::cnt_t'(mswlf_pkg::WINDOW_DEPTH))
    else $error("window count above depth");

  a_flag_bound: assert property (@(posedge clk) disable iff (!rst_n)
    st.flag_cnt <= st.cnt)
    else $error("flag count above item count");

  a_best_ge_win: assert property (@(posedge clk) disable iff (!rst_n)
    out_result.valid |-> (out_result.best_sum >= out_result.window_sum))
    else $error("best sum below window sum");

  a_ovf_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && $past(st.ovf)) |-> st.ovf)
    else $error("overflow flag dropped");
`endif

endmodule

// ===== tb/tb_top.sv =====
// Self-checking bench for max_sum_window_limited_flags: random valid/ready pacing on both
// channels, an item-level window predictor, and per-field result checks.
// Depends on mswlf_pkg, the mswlf_in_if/mswlf_out_if interfaces and the block RTL.
`timescale 1ns / 100ps

module tb_top;

  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam longint unsigned OUT_CAP = (64'd1 << mswlf_pkg::OUT_SUM_W) - 1;
  localparam mswlf_pkg::limit_t LIMIT_MAX = '1;

  typedef struct packed {
    logic               flagged;
    mswlf_pkg::in_val_t value;
  } pending_item_t;

  typedef struct packed {
    mswlf_pkg::osum_t best_sum;
    mswlf_pkg::osum_t window_sum;
    logic             overflow;
  } window_result_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  mswlf_pkg::limit_t cfg_wdata;

  mswlf_in_if  in_if ();
  mswlf_out_if out_if ();

  max_sum_window_limited_flags u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_item    (in_if),
    .out_result (out_if),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  always #5 clk = ~clk;

  // ---------------- window predictor ----------------
  logic              win_flag [mswlf_pkg::WINDOW_DEPTH];
  mswlf_pkg::val_t   win_value [mswlf_pkg::WINDOW_DEPTH];
  mswlf_pkg::addr_t  win_head = '0;
  mswlf_pkg::addr_t  win_tail = '0;
  mswlf_pkg::cnt_t   win_count = '0;
  mswlf_pkg::cnt_t   win_flags = '0;
  mswlf_pkg::sum_t   win_sum = '0;
  mswlf_pkg::sum_t   win_best = '0;
  logic              win_overflow = 1'b0;
  mswlf_pkg::limit_t flag_limit_shadow = '0;

  pending_item_t  item_q[$];
  window_result_t window_results_q[$];
  int unsigned    error_count = 0;
  int unsigned    hold_req = 0;
  int unsigned    hold_left = 0;

  function automatic mswlf_pkg::addr_t wrap_next(mswlf_pkg::addr_t p);
    return mswlf_pkg::addr_t'((int'(p) + 1) % mswlf_pkg::WINDOW_DEPTH);
  endfunction

  function automatic mswlf_pkg::osum_t clip_sum(mswlf_pkg::sum_t s);
    return (64'(s) > OUT_CAP) ? '1 : mswlf_pkg::osum_t'(s);
  endfunction

  // drops the oldest entry, returns its flag
  function automatic logic evict_oldest();
    logic f;
    f = win_flag[win_head];
    win_sum = win_sum - mswlf_pkg::sum_t'(win_value[win_head]);
    if (f && win_flags != 0) win_flags = win_flags - 1'b1;
    win_head = wrap_next(win_head);
    win_count = win_count - 1'b1;
    return f;
  endfunction

  function automatic window_result_t advance_window(logic flagged,
                                                    mswlf_pkg::in_val_t value);
    logic hit;
    window_result_t r;
    if (win_count >= mswlf_pkg::cnt_t'(mswlf_pkg::WINDOW_DEPTH)) begin
      hit = evict_oldest();
      win_overflow = 1'b1;
    end
    win_flag[win_tail] = flagged;
    win_value[win_tail] = mswlf_pkg::val_t'(value);
    win_tail = wrap_next(win_tail);
    win_count = win_count + 1'b1;
    win_sum = win_sum + mswlf_pkg::sum_t'(mswlf_pkg::val_t'(value));
    if (flagged) win_flags = win_flags + 1'b1;
    // evict up to and including the oldest flagged item
    if (win_flags > mswlf_pkg::cnt_t'(flag_limit_shadow)) begin
      hit = 1'b0;
      while (win_count != 0 && !hit) hit = evict_oldest();
    end
    if (win_sum > win_best) win_best = win_sum;
    r.best_sum = clip_sum(win_best);
    r.window_sum = clip_sum(win_sum);
    r.overflow = win_overflow;
    return r;
  endfunction

  function automatic int unsigned gap_length();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // ---------------- item sender ----------------
  int unsigned gap_tx = 0;
  int unsigned calm_tx = 0;

  always @(posedge clk) begin : tx_side
    pending_item_t nxt;
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready)
        window_results_q.push_back(advance_window(in_if.flagged, in_if.value));
      if (!in_if.valid || in_if.ready) begin
        if (gap_tx != 0) begin
          gap_tx--;
          in_if.valid <= 1'b0;
        end else if (item_q.size() != 0) begin
          nxt = item_q.pop_front();
          in_if.valid <= 1'b1;
          in_if.flagged <= nxt.flagged;
          in_if.value <= nxt.value;
          if (calm_tx != 0) calm_tx--;
          else if ($urandom_range(0, 63) == 0) calm_tx = 60;
          else gap_tx = gap_length();
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------- long receiver hold ----------------
  always @(posedge clk) begin : hold_side
    if (!rst_n) begin
      hold_left <= 0;
    end else if (hold_req != 0) begin
      hold_left <= hold_req;
      hold_req = 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // ---------------- result receiver and checker ----------------
  int unsigned stall_rx = 0;
  int unsigned calm_rx = 0;

  always @(posedge clk) begin : rx_side
    window_result_t exp_r;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (window_results_q.size() == 0) begin
          $display("%0t: result with no item pending: best %0d window %0d ovf %0b", $time,
                   out_if.best_sum, out_if.window_sum, out_if.overflow);
          error_count++;
        end else begin
          exp_r = window_results_q.pop_front();
          if (out_if.best_sum !== exp_r.best_sum) begin
            $display("%0t: best_sum expected %0d got %0d", $time, exp_r.best_sum,
                     out_if.best_sum);
            error_count++;
          end
          if (out_if.window_sum !== exp_r.window_sum) begin
            $display("%0t: window_sum expected %0d got %0d", $time, exp_r.window_sum,
                     out_if.window_sum);
            error_count++;
          end
          if (out_if.overflow !== exp_r.overflow) begin
            $display("%0t: overflow expected %0b got %0b", $time, exp_r.overflow,
                     out_if.overflow);
            error_count++;
          end
        end
      end
      if (hold_left != 0) begin
        out_if.ready <= 1'b0;
      end else if (stall_rx != 0) begin
        stall_rx--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
        if (calm_rx != 0) calm_rx--;
        else if ($urandom_range(0, 127) == 0) calm_rx = 150;
        else stall_rx = gap_length();
      end
    end
  end

  // ---------------- run limit ----------------
  int unsigned cycle_count = 0;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d results outstanding", $time, window_results_q.size());
      $display("FAILURE");
      $finish;
    end
  end

  // ---------------- stimulus ----------------
  task automatic queue_item(input logic flagged, input mswlf_pkg::in_val_t value);
    pending_item_t it;
    it.flagged = flagged;
    it.value = value;
    item_q.push_back(it);
  endtask

  // sampled away from the rising edge so the clocked processes have settled
  task automatic wait_idle();
    @(negedge clk);
    while (item_q.size() != 0 || in_if.valid || window_results_q.size() != 0)
      @(negedge clk);
  endtask

  task automatic set_flag_limit(input mswlf_pkg::limit_t lim);
    wait_idle();
    repeat (4) @(posedge clk);
    cfg_wdata <= lim;
    cfg_we <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
    flag_limit_shadow = lim;
  endtask

  task automatic random_burst(input int unsigned n, input int unsigned flag_pct);
    int unsigned r;
    mswlf_pkg::in_val_t v;
    repeat (n) begin
      r = $urandom_range(0, 9);
      if (r == 0) v = '0;
      else if (r == 1) v = '1;
      else if (r < 4) v = mswlf_pkg::in_val_t'($urandom_range(0, 15));
      else v = mswlf_pkg::in_val_t'($urandom);
      queue_item($urandom_range(0, 99) < flag_pct, v);
    end
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_if.valid = 1'b0;
    in_if.flagged = 1'b0;
    in_if.value = '0;
    out_if.ready = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // limit 0 from reset: any flagged item empties the window through itself
    queue_item(1'b0, 16'h0000);
    queue_item(1'b0, 16'hFFFF);
    queue_item(1'b0, 16'hFFFF);
    queue_item(1'b1, 16'h0001);
    queue_item(1'b1, 16'hFFFF);
    queue_item(1'b0, 16'h5555);
    queue_item(1'b0, 16'hAAAA);

    set_flag_limit(mswlf_pkg::limit_t'(1));
    queue_item(1'b1, 16'd100);
    queue_item(1'b0, 16'd200);
    queue_item(1'b1, 16'd300);
    queue_item(1'b1, 16'h0000);
    queue_item(1'b0, 16'hFFFF);

    set_flag_limit(LIMIT_MAX);
    queue_item(1'b1, 16'hFFFF);
    queue_item(1'b1, 16'h8000);
    queue_item(1'b0, 16'h7FFF);
    queue_item(1'b1, 16'h0001);
    queue_item(1'b1, 16'h1234);

    // limit dropped with several flags inside: one flagged eviction per item
    set_flag_limit(mswlf_pkg::limit_t'(0));
    queue_item(1'b0, 16'd7);
    queue_item(1'b0, 16'd9);
    queue_item(1'b0, 16'd11);

    set_flag_limit(mswlf_pkg::limit_t'(0));
    random_burst(50, 25);
    set_flag_limit(mswlf_pkg::limit_t'(1));
    random_burst(50, 30);

    // receiver backs off while items keep coming
    set_flag_limit(mswlf_pkg::limit_t'(2));
    random_burst(50, 30);
    @(negedge clk);
    hold_req = 300;

    set_flag_limit(mswlf_pkg::limit_t'(6));
    random_burst(50, 40);
    set_flag_limit(mswlf_pkg::limit_t'(mswlf_pkg::WINDOW_DEPTH));
    random_burst(50, 50);
    set_flag_limit(mswlf_pkg::limit_t'($urandom_range(0, 2047)));
    random_burst(50, 20);

    // long window with no limit pressure
    set_flag_limit(LIMIT_MAX);
    random_burst(30, 20);

    // lower the limit with many flags inside
    set_flag_limit(mswlf_pkg::limit_t'(3));
    random_burst(20, 10);
    set_flag_limit(mswlf_pkg::limit_t'(0));
    random_burst(20, 30);

    wait_idle();
    repeat (20) @(posedge clk);
    if (error_count == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
